// ===== sv/multilevel_ready_queue_unit_defines.svh =====
// Assertion macros shared by the queue modules.
`ifndef MULTILEVEL_READY_QUEUE_UNIT_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_UNIT_DEFINES_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define MRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that one condition implies another in the same cycle.
`define MRQ_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== sv/mrq_pkg.sv =====
package mrq_pkg;

  localparam int unsigned NumLevelsDef  = 8;
  localparam int unsigned LevelDepthDef = 16;
  localparam int unsigned IdCountDef    = 256;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READY = 2'd1,
    OP_POP   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_NOT_BLOCKED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] proc_id;
    logic       is_ready;
    logic [2:0] prio;
  } in_word_t;

  typedef struct packed {
    logic [7:0] popped_id;
    logic       popped_valid;
    logic       all_empty;
    logic [1:0] status;
  } out_word_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic       enq;     // append id to a level
    logic       pop;     // serve the highest level
    logic       nblk;    // report id not blocked
    logic       clr_blk; // on successful append, clear the blocked record
    logic [7:0] id;
    logic [5:0] lvl;
  } cmd_t;

endpackage

// ===== sv/mrq_ram.sv =====
module mrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/mrq_front.sv =====
`include "multilevel_ready_queue_unit_defines.svh"

// Front part: decodes a word, keeps the blocked table and emits commands.
module mrq_front #(
  parameter int unsigned NumLevels = mrq_pkg::NumLevelsDef,
  parameter int unsigned IdCount   = mrq_pkg::IdCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mrq_pkg::in_word_t in_word_i,
  output logic             cmd_valid_o,
  input  logic             cmd_full_i,
  output mrq_pkg::cmd_t    cmd_o,
  input  logic             clr_valid_i,
  input  logic [7:0]       clr_id_i,
  input  logic             clr_done_i
);

  localparam int unsigned LvlW = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned IdW  = (IdCount > 1) ? $clog2(IdCount) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;
  mrq_pkg::in_word_t word_q;
  logic [IdCount-1:0] blk_valid_q;
  logic               blk_pend_q;
  logic [LvlW-1:0]    blk_prio_rd;
  logic               in_table;
  logic [LvlW-1:0]    lvl_clamped;
  logic               take;
  logic               ram_we;
  logic [IdW-1:0]     prio_raddr;

  // A make-ready word in the back part may still clear its blocked flag, so the
  // input waits until that command is retired.
  assign in_stall_o = (state_q != S_IDLE) || blk_pend_q;
  assign take       = in_valid_i && (state_q == S_IDLE) && !blk_pend_q;
  assign in_table   = (32'(in_word_i.proc_id) < IdCount);
  assign lvl_clamped = (32'(in_word_i.prio) >= NumLevels) ? LvlW'(NumLevels - 1)
                                                          : LvlW'(in_word_i.prio);
  assign ram_we = take && (in_word_i.op == mrq_pkg::OP_PUSH) && !in_word_i.is_ready &&
                  in_table;
  assign prio_raddr = (state_q == S_IDLE) ? IdW'(in_word_i.proc_id) : IdW'(word_q.proc_id);

  mrq_ram #(.Width(LvlW), .Depth(IdCount)) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IdW'(in_word_i.proc_id)),
    .wdata_i(lvl_clamped),
    .raddr_i(prio_raddr),
    .rdata_o(blk_prio_rd)
  );

  logic word_in_table;
  assign word_in_table = (32'(word_q.proc_id) < IdCount);

  always_comb begin
    state_d     = state_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.id    = word_q.proc_id;
    unique case (state_q)
      S_IDLE: begin
        if (take) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (!cmd_full_i) begin
          cmd_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
        unique case (mrq_pkg::op_e'(word_q.op))
          mrq_pkg::OP_PUSH: begin
            cmd_o.enq = word_q.is_ready;
            cmd_o.lvl = 6'((32'(word_q.prio) >= NumLevels) ? (NumLevels - 1)
                                                           : 32'(word_q.prio));
          end
          mrq_pkg::OP_READY: begin
            if (word_in_table && blk_valid_q[IdW'(word_q.proc_id)]) begin
              cmd_o.enq     = 1'b1;
              cmd_o.clr_blk = 1'b1;
              cmd_o.lvl     = 6'(blk_prio_rd);
            end else begin
              cmd_o.nblk = 1'b1;
            end
          end
          mrq_pkg::OP_POP:  cmd_o.pop = 1'b1;
          mrq_pkg::OP_NONE: ;
          default: ;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      blk_valid_q <= '0;
      blk_pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) blk_valid_q[IdW'(in_word_i.proc_id)] <= 1'b1;
      if (clr_valid_i) blk_valid_q[IdW'(clr_id_i)] <= 1'b0;
      if (cmd_valid_o && cmd_o.clr_blk) blk_pend_q <= 1'b1;
      else if (clr_done_i) blk_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) word_q <= in_word_i;
  end

  `MRQ_ASSERT(a_onehot_state, $onehot(state_q), "front state not one-hot")
  `MRQ_ASSERT_IMPL(a_cmd_only_look, cmd_valid_o, state_q == S_LOOK,
                   "command issued outside lookup")
  `MRQ_ASSERT(a_cmd_exclusive, !(cmd_valid_o && cmd_o.enq && cmd_o.pop),
              "command both appends and pops")

endmodule

// ===== sv/mrq_back.sv =====
`include "multilevel_ready_queue_unit_defines.svh"

// Back part: level FIFOs in one RAM, priority search, result register.
module mrq_back #(
  parameter int unsigned NumLevels  = mrq_pkg::NumLevelsDef,
  parameter int unsigned LevelDepth = mrq_pkg::LevelDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_full_o,
  input  mrq_pkg::cmd_t     cmd_i,
  output logic              clr_valid_o,
  output logic [7:0]        clr_id_o,
  output logic              clr_done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mrq_pkg::out_word_t out_word_o
);

  localparam int unsigned LvlW = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned PtrW = (LevelDepth > 1) ? $clog2(LevelDepth) : 1;
  localparam int unsigned CntW = $clog2(LevelDepth + 1);
  localparam int unsigned AdrW = LvlW + PtrW;

  // Two-entry command queue.
  mrq_pkg::cmd_t q_mem_q [2];
  logic          q_wp_q, q_rp_q;
  logic [1:0]    q_cnt_q;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [PtrW-1:0] head_q [NumLevels];
  logic [PtrW-1:0] tail_q [NumLevels];
  logic [CntW-1:0] cnt_q  [NumLevels];
  logic [NumLevels-1:0] nonempty;
  logic [LvlW-1:0] top_lvl;
  logic [LvlW-1:0] pop_lvl_q;
  logic            any_q;
  mrq_pkg::cmd_t   cmd;
  logic            q_pop, q_push;
  logic            ram_we;
  logic [AdrW-1:0] waddr, raddr;
  logic [7:0]      rdata;
  logic [LvlW-1:0] elvl;
  logic            full_lvl;
  logic            res_load;
  mrq_pkg::out_word_t res_d;

  function automatic logic out_valid_o_busy();
    return out_valid_o && out_stall_i;
  endfunction

  assign cmd    = q_mem_q[q_rp_q];
  assign cmd_full_o = (q_cnt_q == 2'd2);
  assign q_push = cmd_valid_i && !cmd_full_o;
  assign elvl   = LvlW'(cmd.lvl);

  always_comb begin
    top_lvl = '0;
    for (int l = 0; l < NumLevels; l++) begin
      nonempty[l] = (cnt_q[l] != '0);
      if (nonempty[l]) top_lvl = LvlW'(l);
    end
  end

  assign full_lvl = (cnt_q[elvl] == CntW'(LevelDepth));
  assign ram_we   = (state_q == S_EXEC) && (q_cnt_q != 2'd0) && !out_valid_o_busy() &&
                    cmd.enq && !full_lvl;
  assign waddr    = {elvl, tail_q[elvl]};
  assign raddr    = {top_lvl, head_q[top_lvl]};

  mrq_ram #(.Width(8), .Depth(2 ** AdrW)) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(cmd.id),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Which levels are nonempty after the current command takes effect.
  logic [NumLevels-1:0] ne_after;
  always_comb begin
    state_d     = state_q;
    q_pop       = 1'b0;
    res_load    = 1'b0;
    res_d       = '0;
    clr_valid_o = 1'b0;
    clr_done_o  = 1'b0;
    clr_id_o    = cmd.id;
    ne_after    = nonempty;
    unique case (state_q)
      S_EXEC: begin
        if (q_cnt_q != 2'd0 && !out_valid_o_busy()) begin
          if (cmd.pop && any_q) begin
            state_d = S_READ;
          end else begin
            q_pop      = 1'b1;
            res_load   = 1'b1;
            clr_done_o = cmd.clr_blk;
            if (cmd.pop) begin
              res_d.status = mrq_pkg::ST_EMPTY;
            end else if (cmd.nblk) begin
              res_d.status = mrq_pkg::ST_NOT_BLOCKED;
            end else if (cmd.enq) begin
              if (full_lvl) begin
                res_d.status = mrq_pkg::ST_FULL;
              end else begin
                ne_after[elvl] = 1'b1;
                clr_valid_o    = cmd.clr_blk;
              end
            end
            res_d.all_empty = (ne_after == '0);
          end
        end
      end
      S_READ: begin
        q_pop    = 1'b1;
        res_load = 1'b1;
        state_d  = S_EXEC;
        res_d.popped_id    = rdata;
        res_d.popped_valid = 1'b1;
        ne_after[pop_lvl_q] = (cnt_q[pop_lvl_q] != CntW'(1));
        res_d.all_empty    = (ne_after == '0);
      end
      default: state_d = S_EXEC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EXEC;
      q_wp_q      <= 1'b0;
      q_rp_q      <= 1'b0;
      q_cnt_q     <= '0;
      out_valid_o <= 1'b0;
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      any_q     <= 1'b0;
      pop_lvl_q <= '0;
    end else begin
      state_q <= state_d;
      if (q_push) q_wp_q <= ~q_wp_q;
      if (q_pop)  q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + 2'(q_push) - 2'(q_pop);
      if (res_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (ram_we) begin
        tail_q[elvl] <= (32'(tail_q[elvl]) == LevelDepth - 1) ? '0 : tail_q[elvl] + 1'b1;
        cnt_q[elvl]  <= cnt_q[elvl] + 1'b1;
      end
      if (state_q == S_EXEC && state_d == S_READ) pop_lvl_q <= top_lvl;
      if (state_q == S_READ) begin
        head_q[pop_lvl_q] <= (32'(head_q[pop_lvl_q]) == LevelDepth - 1) ? '0
                             : head_q[pop_lvl_q] + 1'b1;
        cnt_q[pop_lvl_q]  <= cnt_q[pop_lvl_q] - 1'b1;
      end
      any_q <= (ne_after != '0) && (state_q == S_READ || ram_we) ? 1'b1 :
               (state_q == S_READ) ? 1'b0 : any_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) q_mem_q[q_wp_q] <= cmd_i;
    if (res_load) out_word_o <= res_d;
  end

  `MRQ_ASSERT(a_onehot_state, $onehot(state_q), "back state not one-hot")
  `MRQ_ASSERT(a_queue_bound, q_cnt_q <= 2'd2, "command queue overflow")
  `MRQ_ASSERT_IMPL(a_read_has_cmd, state_q == S_READ, q_cnt_q != 2'd0,
                   "pop read without queued command")

endmodule

// ===== sv/multilevel_ready_queue_unit.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i/in_stall_o   | mrq_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i | mrq_pkg::out_word_t
// An accepted word is registered in the front part and handed on once the command queue has
// room; the back part runs it from that queue and registers its result, and a pop that
// serves an id passes a RAM read state first. The front takes no new word until the last is
// handed on, and a make-ready word that finds its id blocked holds the input until retired.
// Reset is asynchronous and clears the blocked flags, the level pointers and counts.
// A stalled result holds the back part; a two-word command queue lets the front run on.
module multilevel_ready_queue_unit #(
  parameter int unsigned NumLevels  = mrq_pkg::NumLevelsDef,
  parameter int unsigned LevelDepth = mrq_pkg::LevelDepthDef,
  parameter int unsigned IdCount    = mrq_pkg::IdCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mrq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrq_pkg::out_word_t out_word_o
);

  logic          cmd_valid, cmd_full, clr_valid, clr_done;
  logic [7:0]    clr_id;
  mrq_pkg::cmd_t cmd;

  mrq_front #(.NumLevels(NumLevels), .IdCount(IdCount)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_full_i (cmd_full),
    .cmd_o      (cmd),
    .clr_valid_i(clr_valid),
    .clr_id_i   (clr_id),
    .clr_done_i (clr_done)
  );

  mrq_back #(.NumLevels(NumLevels), .LevelDepth(LevelDepth)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_full_o (cmd_full),
    .cmd_i      (cmd),
    .clr_valid_o(clr_valid),
    .clr_id_o   (clr_id),
    .clr_done_o (clr_done),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== bench/multilevel_ready_queue_unit_test.sv =====
module multilevel_ready_queue_unit_test;

  localparam int unsigned NLvl  = mrq_pkg::NumLevelsDef;
  localparam int unsigned Depth = mrq_pkg::LevelDepthDef;
  localparam int unsigned NIds  = mrq_pkg::IdCountDef;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mrq_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mrq_pkg::out_word_t out_word_o;

  multilevel_ready_queue_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow copy of the queue state.
  logic [7:0] lvl_ids [NLvl][$];
  logic       blk_set [NIds];
  logic [2:0] blk_lvl [NIds];

  mrq_pkg::out_word_t result_fifo[$];
  int        n_errors;
  int        n_words_out;
  int        n_pops_served;
  int        send_idle_pct;
  int        recv_idle_pct;
  logic      hold_recv;
  logic      send_hold;

  function automatic logic levels_empty();
    foreach (lvl_ids[l]) if (lvl_ids[l].size() != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic mrq_pkg::status_e append_id(int unsigned l, logic [7:0] id);
    if (lvl_ids[l].size() >= Depth) return mrq_pkg::ST_FULL;
    lvl_ids[l].insert(lvl_ids[l].size(), id);
    return mrq_pkg::ST_OK;
  endfunction

  function automatic mrq_pkg::out_word_t predict_queue(mrq_pkg::in_word_t w);
    mrq_pkg::out_word_t r;
    int unsigned l;
    mrq_pkg::status_e st;
    r = '0;
    st = mrq_pkg::ST_OK;
    l = (w.prio >= NLvl) ? NLvl - 1 : w.prio;
    case (mrq_pkg::op_e'(w.op))
      mrq_pkg::OP_PUSH: begin
        if (w.is_ready) st = append_id(l, w.proc_id);
        else if (w.proc_id < NIds) begin
          blk_set[w.proc_id] = 1'b1;
          blk_lvl[w.proc_id] = 3'(l);
        end
      end
      mrq_pkg::OP_READY: begin
        if (w.proc_id < NIds && blk_set[w.proc_id]) begin
          st = append_id(blk_lvl[w.proc_id], w.proc_id);
          if (st == mrq_pkg::ST_OK) blk_set[w.proc_id] = 1'b0;
        end else begin
          st = mrq_pkg::ST_NOT_BLOCKED;
        end
      end
      mrq_pkg::OP_POP: begin
        st = mrq_pkg::ST_EMPTY;
        for (int k = NLvl - 1; k >= 0; k--) begin
          if (lvl_ids[k].size() != 0) begin
            r.popped_id = lvl_ids[k][0];
            lvl_ids[k].delete(0);
            r.popped_valid = 1'b1;
            st = mrq_pkg::ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.status = st;
    r.all_empty = levels_empty();
    return r;
  endfunction

  // Accepted input words feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      result_fifo.insert(result_fifo.size(), predict_queue(in_word_i));
  end

  always @(posedge clk_i) begin
    mrq_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words_out++;
      if (result_fifo.size() == 0) begin
        $error("unexpected result word %h", out_word_o);
        n_errors++;
      end else begin
        exp_w = result_fifo[0];
        result_fifo.delete(0);
        if (exp_w.popped_valid) n_pops_served++;
        if (out_word_o.popped_id !== exp_w.popped_id) begin
          $error("popped_id: expected %0d, got %0d", exp_w.popped_id, out_word_o.popped_id);
          n_errors++;
        end
        if (out_word_o.popped_valid !== exp_w.popped_valid) begin
          $error("popped_valid: expected %0d, got %0d", exp_w.popped_valid,
                 out_word_o.popped_valid);
          n_errors++;
        end
        if (out_word_o.all_empty !== exp_w.all_empty) begin
          $error("all_empty: expected %0d, got %0d", exp_w.all_empty, out_word_o.all_empty);
          n_errors++;
        end
        if (out_word_o.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_word_o.status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Directed words; a typed-in result is checked on top of the predictor.
  typedef struct {
    mrq_pkg::op_e       op;
    logic [7:0]         id;
    logic               rdy;
    logic [2:0]         prio;
    logic               has_exp;
    mrq_pkg::out_word_t exp_w;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic mrq_pkg::out_word_t mk_res(logic [7:0] id, logic v, logic e,
                                                mrq_pkg::status_e s);
    mrq_pkg::out_word_t r;
    r.popped_id = id;
    r.popped_valid = v;
    r.all_empty = e;
    r.status = s;
    return r;
  endfunction

  function automatic void add_row(mrq_pkg::op_e op, logic [7:0] id, logic rdy,
                                  logic [2:0] prio, logic has_exp,
                                  mrq_pkg::out_word_t exp_w);
    dir_row_t d;
    d.op = op;
    d.id = id;
    d.rdy = rdy;
    d.prio = prio;
    d.has_exp = has_exp;
    d.exp_w = exp_w;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  task automatic send_word(mrq_pkg::in_word_t w);
    while (send_hold || ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_fifo.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic mrq_pkg::in_word_t rand_word(int unsigned kind);
    mrq_pkg::in_word_t w;
    w.proc_id = $urandom_range(255);
    w.is_ready = $urandom_range(1);
    w.prio = $urandom_range(7);
    if (kind < 40) w.op = mrq_pkg::OP_PUSH;
    else if (kind < 60) w.op = mrq_pkg::OP_READY;
    else if (kind < 97) w.op = mrq_pkg::OP_POP;
    else w.op = mrq_pkg::OP_NONE;
    // Make-ready words mostly aim at small ids, which are often blocked.
    if (w.op == mrq_pkg::OP_READY && $urandom_range(3) != 0) w.proc_id = $urandom_range(15);
    if (w.op == mrq_pkg::OP_PUSH && !w.is_ready && $urandom_range(3) != 0)
      w.proc_id = $urandom_range(15);
    return w;
  endfunction

  task automatic random_phase(int n_words, int unsigned pop_bias);
    mrq_pkg::in_word_t w;
    for (int i = 0; i < n_words; i++) begin
      w = rand_word($urandom_range(99));
      if (w.op == mrq_pkg::OP_PUSH && $urandom_range(99) < pop_bias) w.op = mrq_pkg::OP_POP;
      send_word(w);
    end
  endtask

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    mrq_pkg::in_word_t w;
    int hold_cnt;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    hold_recv = 1'b0;
    send_hold = 1'b0;
    n_errors = 0;
    n_words_out = 0;
    n_pops_served = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (blk_set[i]) blk_set[i] = 1'b0;
    foreach (blk_lvl[i]) blk_lvl[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b1,
            mk_res(8'd0, 1'b0, 1'b1, mrq_pkg::ST_EMPTY));
    add_row(mrq_pkg::OP_READY, 8'd5, 1'b0, 3'd0, 1'b1,
            mk_res(8'd0, 1'b0, 1'b1, mrq_pkg::ST_NOT_BLOCKED));
    add_row(mrq_pkg::OP_NONE, 8'hff, 1'b1, 3'd7, 1'b1,
            mk_res(8'd0, 1'b0, 1'b1, mrq_pkg::ST_OK));
    add_row(mrq_pkg::OP_PUSH, 8'd0, 1'b1, 3'd0, 1'b1,
            mk_res(8'd0, 1'b0, 1'b0, mrq_pkg::ST_OK));
    add_row(mrq_pkg::OP_PUSH, 8'hff, 1'b1, 3'd7, 1'b0, '0);
    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b1,
            mk_res(8'hff, 1'b1, 1'b0, mrq_pkg::ST_OK));
    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b1,
            mk_res(8'd0, 1'b1, 1'b1, mrq_pkg::ST_OK));
    add_row(mrq_pkg::OP_PUSH, 8'd9, 1'b0, 3'd5, 1'b1,
            mk_res(8'd0, 1'b0, 1'b1, mrq_pkg::ST_OK));
    add_row(mrq_pkg::OP_PUSH, 8'd9, 1'b0, 3'd2, 1'b0, '0);
    add_row(mrq_pkg::OP_PUSH, 8'd9, 1'b1, 3'd6, 1'b0, '0);
    add_row(mrq_pkg::OP_READY, 8'd9, 1'b0, 3'd0, 1'b0, '0);
    add_row(mrq_pkg::OP_READY, 8'd9, 1'b0, 3'd0, 1'b0, '0);
    add_row(mrq_pkg::OP_PUSH, 8'haa, 1'b0, 3'd7, 1'b0, '0);
    add_row(mrq_pkg::OP_PUSH, 8'h55, 1'b1, 3'd3, 1'b0, '0);
    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b0, '0);
    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b0, '0);
    add_row(mrq_pkg::OP_POP, 8'd0, 1'b0, 3'd0, 1'b0, '0);
    // Fill level 4 past its depth, then make-ready into the full level.
    for (int i = 0; i < 17; i++)
      add_row(mrq_pkg::OP_PUSH, 8'(i + 100), 1'b1, 3'd4, 1'b0, '0);
    add_row(mrq_pkg::OP_PUSH, 8'd7, 1'b0, 3'd4, 1'b0, '0);
    add_row(mrq_pkg::OP_READY, 8'd7, 1'b0, 3'd0, 1'b0, '0);

    foreach (dir_rows[i]) begin
      w.op = dir_rows[i].op;
      w.proc_id = dir_rows[i].id;
      w.is_ready = dir_rows[i].rdy;
      w.prio = dir_rows[i].prio;
      if (dir_rows[i].has_exp) begin
        // Typed-in rows are sent alone, so the predictor entry lines up.
        drain_results();
        send_word(w);
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        if (result_fifo[$] !== dir_rows[i].exp_w) begin
          $error("directed row %0d: expected %h, predictor %h", i, dir_rows[i].exp_w,
                 result_fifo[$]);
          n_errors++;
        end
        @(posedge clk_i);
      end else begin
        send_word(w);
      end
    end
    drain_results();
    repeat (20) @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 63;
    random_phase(500, 0);

    // Long hold on the output while words keep coming in.
    send_idle_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        hold_cnt = 0;
        while (hold_cnt < 200) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        hold_recv = 1'b0;
      end
      random_phase(30, 0);
    join
    // Sender pauses until every result is back.
    send_hold = 1'b1;
    drain_results();
    send_hold = 1'b0;

    send_idle_pct = 63;
    recv_idle_pct = 33;
    random_phase(500, 20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600, 10);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (result_fifo.size() != 0) begin
      $error("%0d result words never arrived", result_fifo.size());
      n_errors++;
    end
    $display("Covered %0d result words, %0d served pops, across push, make-ready, pop",
             n_words_out, n_pops_served);
    $display("and the unused op, with full levels, empty pops and long output holds.");
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mrq_pkg.sv
sv/mrq_ram.sv
sv/mrq_front.sv
sv/mrq_back.sv
sv/multilevel_ready_queue_unit.sv
bench/multilevel_ready_queue_unit_test.sv
